// ===== hdl/lnf_pkg.sv =====
package lnf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int CNT_W         = 4 * NUMBER_DIGITS;
  localparam int POS_W         = $clog2(NUMBER_DIGITS + 3);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_LINE_ENDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_CONTROL    = 3'd5;

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QMARK    = 8'd63;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_line_ends;
    logic show_tabs;
    logic show_control;
  } lnf_cfg_t;

  // one classified input byte waiting for the back end
  typedef struct packed {
    logic                     has_number;
    logic [CNT_W-1:0]         digits;
    logic [NUMBER_DIGITS-1:0] digit_shown;
    logic                     has_mark;
    logic [7:0]               mark_byte;
    logic [7:0]               ch;
  } lnf_item_t;

endpackage

// ===== hdl/lnf_front.sv =====
module lnf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                         cfg_data,
  input  logic                         in_take,
  input  logic [7:0]                   in_byte,
  output logic                         item_valid,
  output lnf_pkg::lnf_item_t           item
);
  import lnf_pkg::*;

  lnf_cfg_t         cfg;
  logic [CNT_W-1:0] line_count;
  logic [CNT_W-1:0] line_count_next;
  logic             await_all;
  logic             await_nonblank;
  logic             last_was_newline;
  logic [1:0]       blank_run;
  logic [1:0]       blank_run_inc;

  logic nl;
  logic squeeze_hit;
  logic drop;
  logic number_all_mode;
  logic emit_number;
  logic all_nines;
  logic carry;
  logic seen;
  logic [3:0] d;
  logic [NUMBER_DIGITS-1:0] shown;
  logic has_mark;
  logic [7:0] ch_out;

  assign nl              = (in_byte == CH_NL);
  assign squeeze_hit     = cfg.squeeze_blank && nl && last_was_newline;
  assign blank_run_inc   = (blank_run == 2'd2) ? 2'd2 : blank_run + 2'd1;
  assign drop            = squeeze_hit && (blank_run_inc == 2'd2);
  assign number_all_mode = cfg.number_all && !cfg.number_nonblank;
  assign emit_number     = (number_all_mode && await_all) ||
                           (cfg.number_nonblank && !nl && await_nonblank);

  // bcd increment with saturation, and leading-blank mask
  always_comb begin
    line_count_next = line_count;
    carry = 1'b1;
    all_nines = 1'b1;
    seen = 1'b0;
    d = 4'd0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = line_count[4*i +: 4];
      if (d != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (d == 4'd9) begin
          line_count_next[4*i +: 4] = 4'd0;
        end else begin
          line_count_next[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) line_count_next = line_count;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (line_count[4*i +: 4] != 4'd0 || i == 0) seen = 1'b1;
      shown[i] = seen;
    end
  end

  always_comb begin
    has_mark = 1'b0;
    ch_out   = in_byte;
    if (cfg.show_line_ends && nl) has_mark = 1'b1;
    if (cfg.show_tabs && in_byte == CH_TAB) begin
      has_mark = 1'b1;
      ch_out   = CH_I;
    end else if (cfg.show_control) begin
      if (in_byte < CH_TAB || (in_byte > CH_NL && in_byte < CH_SPACE)) begin
        has_mark = 1'b1;
        ch_out   = in_byte + CTRL_OFFSET;
      end else if (in_byte == CH_DEL) begin
        has_mark = 1'b1;
        ch_out   = CH_QMARK;
      end
    end
  end

  assign item_valid       = in_take && !drop;
  assign item.has_number  = emit_number;
  assign item.digits      = line_count;
  assign item.digit_shown = shown;
  assign item.has_mark    = has_mark;
  assign item.mark_byte   = nl ? CH_DOLLAR : CH_CARET;
  assign item.ch          = ch_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg              <= '0;
      line_count       <= {{(CNT_W-1){1'b0}}, 1'b1};
      await_all        <= 1'b1;
      await_nonblank   <= 1'b1;
      last_was_newline <= 1'b1;
      blank_run        <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NUMBER_ALL:      cfg.number_all      <= cfg_data;
          REG_NUMBER_NONBLANK: cfg.number_nonblank <= cfg_data;
          REG_SQUEEZE_BLANK:   cfg.squeeze_blank   <= cfg_data;
          REG_SHOW_LINE_ENDS:  cfg.show_line_ends  <= cfg_data;
          REG_SHOW_TABS:       cfg.show_tabs       <= cfg_data;
          REG_SHOW_CONTROL:    cfg.show_control    <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        blank_run <= squeeze_hit ? blank_run_inc : 2'd0;
        if (!drop) begin
          if (number_all_mode) await_all <= nl;
          if (cfg.number_nonblank) await_nonblank <= nl;
          if (emit_number) line_count <= line_count_next;
          last_was_newline <= nl;
        end
      end
    end
  end

endmodule

// ===== hdl/lnf_queue.sv =====
module lnf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  lnf_pkg::lnf_item_t wr_item,
  output logic               full,
  input  logic               rd_en,
  output logic               not_empty,
  output lnf_pkg::lnf_item_t rd_item
);
  import lnf_pkg::*;

  lnf_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QPTR_W:0]    count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) tail <= tail + 1'b1;
      if (rd_en) head <= head + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries[tail] <= wr_item;
  end

endmodule

// ===== hdl/lnf_back.sv =====
module lnf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_avail,
  input  lnf_pkg::lnf_item_t item,
  output logic               item_done,
  output logic               out_valid,
  input  logic               out_take,
  output logic [7:0]         out_byte,
  output logic               run_end
);
  import lnf_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] body_start;
  logic [POS_W-1:0] last_pos;
  logic [3:0]       digit;
  logic             shown;
  logic [7:0]       cur_byte;
  logic             is_last;
  logic             advance;

  assign body_start = item.has_number ? POS_W'(NUMBER_DIGITS + 1) : '0;
  assign last_pos   = body_start + {{(POS_W-1){1'b0}}, item.has_mark};
  assign is_last    = (pos == last_pos);
  assign advance    = !out_valid || out_take;
  assign item_done  = advance && item_avail && is_last;

  // most significant digit goes out first
  always_comb begin
    digit = 4'd0;
    shown = 1'b0;
    for (int j = 0; j < NUMBER_DIGITS; j++) begin
      if (pos == POS_W'(NUMBER_DIGITS - 1 - j)) begin
        digit = item.digits[4*j +: 4];
        shown = item.digit_shown[j];
      end
    end
  end

  always_comb begin
    if (item.has_number && pos < POS_W'(NUMBER_DIGITS)) begin
      cur_byte = shown ? CH_ZERO + {4'd0, digit} : CH_SPACE;
    end else if (item.has_number && pos == POS_W'(NUMBER_DIGITS)) begin
      cur_byte = CH_TAB;
    end else if (item.has_mark && pos == body_start) begin
      cur_byte = item.mark_byte;
    end else begin
      cur_byte = item.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= item_avail;
      if (item_avail) pos <= is_last ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_avail) begin
      out_byte <= cur_byte;
      run_end  <= is_last;
    end
  end

endmodule

// ===== hdl/text_stream_line_number_filter_core.sv =====
// text stream line-number filter: rewrites a byte stream one byte at a time
// input side is a queue write port: in_byte is taken at an edge with push
// high and full low; one byte per cycle is accepted while full stays low
// output side is a queue read port: out_byte/run_end hold the oldest byte
// while empty is low and leave at an edge with pop high; run_end marks the
// last byte produced for one input byte (a squeezed blank line gives none)
// each input byte yields zero to nine output bytes (line number prefix of
// six digits and a tab, an optional '$' or '^' mark, the byte itself)
// an input byte enters the queue as it is taken; with the back end idle, its
// first output byte is registered from the head; throughput is one output
// byte per cycle with pop high, so plain bytes run one per cycle in and out
// the rate is set by the back end, which emits one byte a cycle from the
// head of a four-entry queue; the front end classifies at one byte a cycle
// when pop is held low the output byte holds, the queue fills and full rises
// configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and are meant for idle periods; reset clears all modes, sets the line
// number to one, and empties queue and output
module text_stream_line_number_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          run_end
);
  import lnf_pkg::*;

  logic      in_take;
  logic      item_valid;
  lnf_item_t item_in;
  lnf_item_t item_head;
  logic      head_avail;
  logic      head_done;
  logic      out_valid;

  assign in_take = push && !full;
  assign empty   = !out_valid;

  lnf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_take    (in_take),
    .in_byte    (in_byte),
    .item_valid (item_valid),
    .item       (item_in)
  );

  lnf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (item_valid),
    .wr_item   (item_in),
    .full      (full),
    .rd_en     (head_done),
    .not_empty (head_avail),
    .rd_item   (item_head)
  );

  lnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_avail (head_avail),
    .item       (item_head),
    .item_done  (head_done),
    .out_valid  (out_valid),
    .out_take   (pop),
    .out_byte   (out_byte),
    .run_end    (run_end)
  );

endmodule

// ===== hdl/lnf_checker.sv =====
module lnf_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       run_end
);

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_end)))
    else $error("output byte changed while stalled");

  // bytes of one run follow without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !run_end) |=> !empty)
    else $error("gap inside an output run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output not empty after reset");

  a_reset_not_full: assert property (@(posedge clk)
    rst |=> !full)
    else $error("queue full after reset");

endmodule

bind text_stream_line_number_filter_core lnf_checker u_lnf_checker (.*);

// ===== verif/tb_text_stream_line_number_filter_core.sv =====
module tb_text_stream_line_number_filter_core;
  import lnf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 33;

  // indexes outside the register map, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_SHOW_CONTROL + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = '1;

  // field order: number_all, number_nonblank, squeeze, line_ends, tabs, control
  localparam lnf_cfg_t CFG_PLAIN    = 6'b000000;
  localparam lnf_cfg_t CFG_MARKS    = 6'b000111;
  localparam lnf_cfg_t CFG_NUM_SQZ  = 6'b101000;
  localparam lnf_cfg_t CFG_NONBLANK = 6'b110000;
  localparam lnf_cfg_t CFG_ALL_ON   = 6'b111111;
  localparam lnf_cfg_t CFG_NUM_MARK = 6'b101111;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_rec_t;

  // n_lit: 0 = use the prediction, 1 or 2 = typed-in output bytes
  typedef struct packed {
    lnf_cfg_t   cfg;
    logic [7:0] b;
    logic [1:0] n_lit;
    logic [7:0] lit0;
    logic [7:0] lit1;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data  = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  logic [7:0]           in_byte   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic [7:0]           out_byte;
  logic                 run_end;

  text_stream_line_number_filter_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_end   (run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter model state
  lnf_cfg_t         model_cfg;
  logic [CNT_W-1:0] line_bcd;
  logic             want_num_all;
  logic             want_num_nb;
  logic             prev_nl;
  logic [1:0]       blank_cnt;

  out_rec_t step_out[$];
  out_rec_t pending_bytes[$];
  out_rec_t head_rec;

  int errors        = 0;
  int stall_cycles  = 0;
  int send_gap_pct  = 0;
  int recv_gap_pct  = 0;

  dir_row_t directed_rows [0:23];

  function automatic void emit(input logic [7:0] b);
    step_out.push_back('{b, 1'b0});
  endfunction

  function automatic void append_line_number();
    logic       shown;
    logic       nines;
    logic [3:0] d;
    shown = 1'b0;
    nines = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      d = line_bcd[4*i +: 4];
      if (d != 4'd0 || i == 0) shown = 1'b1;
      emit(shown ? CH_ZERO + {4'd0, d} : CH_SPACE);
      if (d != 4'd9) nines = 1'b0;
    end
    emit(CH_TAB);
    // bcd increment, held once every digit is nine
    if (!nines) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (line_bcd[4*i +: 4] < 4'd9) begin
          line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
          break;
        end
        line_bcd[4*i +: 4] = 4'd0;
      end
    end
  endfunction

  function automatic void rewrite_byte(input logic [7:0] b);
    logic [7:0] ch;
    logic       nl;
    ch = b;
    nl = (b == CH_NL);
    step_out.delete();
    if (model_cfg.squeeze_blank && nl && prev_nl) begin
      if (blank_cnt < 2'd2) blank_cnt++;
      if (blank_cnt > 2'd1) return;
    end else begin
      blank_cnt = 2'd0;
    end
    if (model_cfg.number_all && !model_cfg.number_nonblank) begin
      if (want_num_all) begin
        append_line_number();
        want_num_all = 1'b0;
      end
      if (nl) want_num_all = 1'b1;
    end
    if (model_cfg.number_nonblank) begin
      if (nl) begin
        want_num_nb = 1'b1;
      end else if (want_num_nb) begin
        append_line_number();
        want_num_nb = 1'b0;
      end
    end
    if (model_cfg.show_line_ends && nl) emit(CH_DOLLAR);
    if (model_cfg.show_tabs && ch == CH_TAB) begin
      emit(CH_CARET);
      ch = CH_I;
    end
    if (model_cfg.show_control) begin
      if (ch < CH_TAB || (ch > CH_NL && ch < CH_SPACE)) begin
        emit(CH_CARET);
        ch = ch + CTRL_OFFSET;
      end else if (ch == CH_DEL) begin
        emit(CH_CARET);
        ch = CH_QMARK;
      end
    end
    step_out.push_back('{ch, 1'b1});
    prev_nl = nl;
  endfunction

  // mostly text lines; the rest tabs, control bytes, DEL, high bytes, noise
  function automatic logic [7:0] rand_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CH_NL;
    if (r < 33) return CH_TAB;
    if (r < 43) return 8'($urandom_range(31));
    if (r < 47) return CH_DEL;
    if (r < 55) return 8'($urandom_range(255, 128));
    if (r < 65) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_NUMBER_ALL:      model_cfg.number_all      = val;
      REG_NUMBER_NONBLANK: model_cfg.number_nonblank = val;
      REG_SQUEEZE_BLANK:   model_cfg.squeeze_blank   = val;
      REG_SHOW_LINE_ENDS:  model_cfg.show_line_ends  = val;
      REG_SHOW_TABS:       model_cfg.show_tabs       = val;
      REG_SHOW_CONTROL:    model_cfg.show_control    = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait for the block to drain, then rewrite every mode register
  task automatic load_config(input lnf_cfg_t c, input logic poke_unmapped);
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    // a squeezed newline may still be in flight with nothing expected
    repeat (4) @(negedge clk);
    write_reg(REG_NUMBER_ALL, c.number_all);
    write_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
    write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
    write_reg(REG_SHOW_LINE_ENDS, c.show_line_ends);
    write_reg(REG_SHOW_TABS, c.show_tabs);
    write_reg(REG_SHOW_CONTROL, c.show_control);
    if (poke_unmapped) begin
      write_reg(REG_UNMAPPED_FIRST, 1'b1);
      write_reg(REG_UNMAPPED_LAST, 1'b1);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic [1:0] n_lit,
                           input logic [7:0] lit0, input logic [7:0] lit1);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    rewrite_byte(b);
    if (n_lit == 2'd0) begin
      foreach (step_out[k]) pending_bytes.push_back(step_out[k]);
    end else begin
      if (n_lit == 2'd2) pending_bytes.push_back('{lit0, 1'b0});
      pending_bytes.push_back('{(n_lit == 2'd2) ? lit1 : lit0, 1'b1});
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %h run_end %b", $time, out_byte, run_end);
        end else begin
          head_rec = pending_bytes.pop_front();
          if (out_byte !== head_rec.b) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, head_rec.b, out_byte);
          end
          if (run_end !== head_rec.last) begin
            errors++;
            $display("%0t: run_end expected %b actual %b", $time, head_rec.last, run_end);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_text_stream_line_number_filter_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    lnf_cfg_t ph_cfg;
    model_cfg    = CFG_PLAIN;
    line_bcd     = 1;
    want_num_all = 1'b1;
    want_num_nb  = 1'b1;
    prev_nl      = 1'b1;
    blank_cnt    = 2'd0;

    directed_rows = '{
      '{CFG_PLAIN,    "A",       2'd1, "A",       8'h00},
      '{CFG_PLAIN,    8'h00,     2'd1, 8'h00,     8'h00},
      '{CFG_PLAIN,    8'hFF,     2'd1, 8'hFF,     8'h00},
      '{CFG_PLAIN,    CH_DEL,    2'd1, CH_DEL,    8'h00},
      '{CFG_PLAIN,    CH_TAB,    2'd1, CH_TAB,    8'h00},
      '{CFG_PLAIN,    CH_NL,     2'd1, CH_NL,     8'h00},
      '{CFG_MARKS,    8'h01,     2'd2, CH_CARET,  "A"},
      '{CFG_MARKS,    CH_DEL,    2'd2, CH_CARET,  CH_QMARK},
      // the byte after DEL must still come out
      '{CFG_MARKS,    "x",       2'd1, "x",       8'h00},
      '{CFG_MARKS,    CH_TAB,    2'd2, CH_CARET,  CH_I},
      '{CFG_MARKS,    CH_NL,     2'd2, CH_DOLLAR, CH_NL},
      '{CFG_MARKS,    8'h1F,     2'd2, CH_CARET,  "_"},
      '{CFG_MARKS,    8'h80,     2'd1, 8'h80,     8'h00},
      '{CFG_NUM_SQZ,  "a",       2'd0, 8'h00,     8'h00},
      '{CFG_NUM_SQZ,  CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NUM_SQZ,  CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NUM_SQZ,  CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NUM_SQZ,  CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NUM_SQZ,  "b",       2'd0, 8'h00,     8'h00},
      // non-blank numbering overrides number-all
      '{CFG_NONBLANK, CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NONBLANK, "c",       2'd0, 8'h00,     8'h00},
      '{CFG_NONBLANK, CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NONBLANK, CH_NL,     2'd0, 8'h00,     8'h00},
      '{CFG_NONBLANK, "d",       2'd0, 8'h00,     8'h00}
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct = 9;
    recv_gap_pct = 57;
    foreach (directed_rows[r]) begin
      if (r == 0 || directed_rows[r].cfg != model_cfg)
        load_config(directed_rows[r].cfg, 1'b0);
      send_byte(directed_rows[r].b, directed_rows[r].n_lit,
                directed_rows[r].lit0, directed_rows[r].lit1);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ph_cfg = CFG_ALL_ON;
        2: ph_cfg = CFG_NUM_MARK;
        4: ph_cfg = CFG_PLAIN;
        default: ph_cfg = lnf_cfg_t'($urandom_range(63));
      endcase
      if (ph < 2) begin
        send_gap_pct = 9;
        recv_gap_pct = 57;
      end else if (ph < 4) begin
        send_gap_pct = 57;
        recv_gap_pct = 9;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      load_config(ph_cfg, ph == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender until the output side has caught up
        if (ph == 3 && k == 18) begin
          push <= 1'b0;
          while (pending_bytes.size() != 0) @(negedge clk);
          @(negedge clk);
        end
        send_byte(rand_text_byte(), 2'd0, 8'h00, 8'h00);
      end
    end

    push <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("tb_text_stream_line_number_filter_core: PASS");
    end else begin
      $display("tb_text_stream_line_number_filter_core: FAIL");
    end
    $finish;
  end

endmodule
